// ===== design/stc_pkg.sv =====
// stc_pkg: shared types, widths and calendar helpers for summer_time_correction
// depends on nothing; imported by summer_time_correction
package stc_pkg;

    localparam int YEAR_W  = 7;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int WDAY_W  = 3;
    localparam int HOUR_W  = 5;
    localparam int SUM_W   = 8;

    // month codes used by the summer rule
    localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_OCT = 4'd10;

    localparam logic [WDAY_W-1:0] WDAY_MON = 3'd1;
    localparam logic [WDAY_W-1:0] WDAY_SUN = 3'd7;
    localparam logic [HOUR_W-1:0] HOUR_SWITCH = 5'd2;
    localparam logic [HOUR_W-1:0] HOURS_PER_DAY = 5'd24;
    localparam logic [DAY_W-1:0] DAY_LAST = 5'd31;

    // input beat
    typedef struct packed {
        logic [YEAR_W-1:0]  year_offset;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [WDAY_W-1:0]  weekday;
        logic [HOUR_W-1:0]  hour;
    } t_in_item;

    // result beat
    typedef struct packed {
        logic               summer_active;
        logic [YEAR_W-1:0]  local_year_offset;
        logic [MONTH_W-1:0] local_month;
        logic [DAY_W-1:0]   local_day;
        logic [WDAY_W-1:0]  local_weekday;
        logic [HOUR_W-1:0]  local_hour;
    } t_out_item;

    // weekday offset table, indexed by month 1..12
    function automatic logic [2:0] month_key(input logic [MONTH_W-1:0] m);
        logic [2:0] k;
        begin
            unique case (m)
                4'd1:    k = 3'd0;
                4'd2:    k = 3'd3;
                4'd3:    k = 3'd2;
                4'd4:    k = 3'd5;
                4'd5:    k = 3'd0;
                4'd6:    k = 3'd3;
                4'd7:    k = 3'd5;
                4'd8:    k = 3'd1;
                4'd9:    k = 3'd4;
                4'd10:   k = 3'd6;
                4'd11:   k = 3'd2;
                4'd12:   k = 3'd4;
                default: k = 3'd0;
            endcase
            return k;
        end
    endfunction

    // days in month; february follows the low two year bits
    function automatic logic [DAY_W-1:0] month_length(input logic [YEAR_W-1:0] y,
                                                      input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        begin
            unique case (m)
                4'd2:    len = (y[1:0] != 2'd0) ? 5'd28 : 5'd29;
                4'd4,
                4'd6,
                4'd9,
                4'd11:   len = 5'd30;
                default: len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

// ===== design/summer_time_correction.sv =====
// summer_time_correction: standard time to local time with eu summer time rule
// depends on stc_pkg (types, month table, month lengths)
//
//  channel   handshake         payload       notes
//  input     start / busy      i_item        beat taken when start & !busy
//  result    o_done (strobe)   o_result      valid for one cycle, cannot stall
//
// three register stages: key sum, weekday of the 31st, rule and rollover.
// one beat per cycle sustained; accept passes through r_v1, r_v2 and r_v3 to o_done.
// busy stays low: the receiver never stalls, so no stage ever has to hold.
// synchronous active-low reset clears the valid bits only.
module summer_time_correction
    import stc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_done,
    output t_out_item o_result
);

    // stage 1 registers
    logic             r_v1;
    t_in_item         r_it1;
    logic [SUM_W-1:0] r_sum1;
    logic             r_edge1;
    logic             r_mid1;
    logic [SUM_W-1:0] n_sum1;

    // stage 2 registers
    logic             r_v2;
    t_in_item         r_it2;
    logic [DAY_W-1:0] r_ls2;
    logic             r_edge2;
    logic             r_mid2;
    logic [DAY_W-1:0] n_ls2;

    // stage 3 registers
    logic      r_v3;
    t_out_item r_res;
    t_out_item n_res;

    logic accept;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // stage 1: weekday key sum for day 31 (y + y/4 + key + 31 + 6)
    always_comb begin
        n_sum1 = {1'b0, i_item.year_offset}
               + {3'b000, i_item.year_offset[YEAR_W-1:2]}
               + {5'b00000, month_key(i_item.month)}
               + 8'd37;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= accept;
        end
        r_it1   <= i_item;
        r_sum1  <= n_sum1;
        r_edge1 <= (i_item.month == MONTH_MAR) || (i_item.month == MONTH_OCT);
        r_mid1  <= (i_item.month >= MONTH_APR) && (i_item.month <= MONTH_SEP);
    end

    // stage 2: sum mod 7 by octal digit folding, then last sunday
    always_comb begin
        logic [4:0] fold_a;
        logic [3:0] fold_b;
        logic [2:0] rem;
        logic [WDAY_W:0] wd31;
        fold_a = {2'b00, r_sum1[2:0]} + {2'b00, r_sum1[5:3]} + {3'b000, r_sum1[7:6]};
        fold_b = {1'b0, fold_a[2:0]} + {2'b00, fold_a[4:3]};
        rem    = (fold_b >= 4'd7) ? 3'(fold_b - 4'd7) : fold_b[2:0];
        wd31   = {1'b0, rem} + 4'd1;
        n_ls2  = (wd31 == {1'b0, WDAY_SUN}) ? DAY_LAST : DAY_LAST - DAY_W'(wd31);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_it2   <= r_it1;
        r_ls2   <= n_ls2;
        r_edge2 <= r_edge1;
        r_mid2  <= r_mid1;
    end

    // stage 3: rule decision and one hour advance with day and month rollover
    always_comb begin
        logic            pre_switch;
        logic            on;
        logic [HOUR_W:0] h_inc;
        logic [DAY_W:0]  d_inc;
        logic [WDAY_W:0] w_inc;
        pre_switch = (r_it2.day < r_ls2)
                  || ((r_it2.day == r_ls2) && (r_it2.hour < HOUR_SWITCH));
        if (r_edge2) begin
            on = (r_it2.month == MONTH_MAR) ? ~pre_switch : pre_switch;
        end else begin
            on = r_mid2;
        end
        h_inc = {1'b0, r_it2.hour} + 6'd1;
        d_inc = {1'b0, r_it2.day} + 6'd1;
        w_inc = {1'b0, r_it2.weekday} + 4'd1;

        n_res.summer_active     = on;
        n_res.local_year_offset = r_it2.year_offset;
        n_res.local_month       = r_it2.month;
        n_res.local_day         = r_it2.day;
        n_res.local_weekday     = r_it2.weekday;
        n_res.local_hour        = r_it2.hour;
        if (on) begin
            if (h_inc >= {1'b0, HOURS_PER_DAY}) begin
                n_res.local_hour    = '0;
                n_res.local_weekday = (w_inc > {1'b0, WDAY_SUN}) ? WDAY_MON
                                                                 : w_inc[WDAY_W-1:0];
                if (d_inc > {1'b0, month_length(r_it2.year_offset, r_it2.month)}) begin
                    n_res.local_day   = DAY_W'(1);
                    n_res.local_month = r_it2.month + MONTH_W'(1);
                end else begin
                    n_res.local_day = d_inc[DAY_W-1:0];
                end
            end else begin
                n_res.local_hour = h_inc[HOUR_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_res <= n_res;
    end

    assign o_done   = r_v3;
    assign o_result = r_res;

endmodule
